>>> src/slcf_pkg.sv
// Shared types and constants for the staggered LED crossfade unit.
// No dependencies.
`timescale 1ns / 1ps

package slcf_pkg;

	// Field widths fixed by the item format
	localparam int CMD_W    = 2;
	localparam int IDX_W    = 6;
	localparam int COLOUR_W = 24;
	localparam int ORDER_W  = 6;
	localparam int TICK_W   = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int GROUP_W  = 7;
	localparam int BEGIN_W  = 22;   // stagger (16b) times order group (6b)

	// Command codes
	localparam logic [CMD_W-1:0] CMD_WR_START = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WR_END   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WR_ORDER = 2'd2;
	localparam logic [CMD_W-1:0] CMD_EVAL     = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STAGGER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FADE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP   = 2'd2;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_ORD_LD,
		S_ORD_DIV,
		S_BEGIN,
		S_CMP,
		S_MUL,
		S_DIV,
		S_ACC,
		S_FINISH
	} state_t;

endpackage

>>> src/staggered_led_crossfade_unit.sv
// Staggered LED crossfade: per-LED color/order storage and a sequencer
// around one shared 8-step restoring divider. Depends on slcf_pkg.
//
// A write item goes from S_IDLE to S_FINISH; a mid-fade evaluate runs seven
// 8-step divisions on the shared divider (one for the order group, two per
// color channel); an evaluate before the start, at or past the end, or out of
// range stops after the order group division. The next item is taken the cycle
// after the result enters the output register; S_FINISH holds while out_valid
// is set and out_ready is low. Reset clears state, out_valid, stagger and fade,
// and sets the group size to one; it does not clear the memories.
`timescale 1ns / 1ps

module staggered_led_crossfade_unit
	import slcf_pkg::*;
#(
	parameter int LED_TOTAL = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input items
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [IDX_W-1:0]      led_index,
	input  logic [COLOUR_W-1:0]   colour_in,
	input  logic [ORDER_W-1:0]    order_value,
	input  logic [TICK_W-1:0]     time_tick,
	// result items
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COLOUR_W-1:0]   colour_out,
	output logic                  fade_done
);

	localparam int AW = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;
	localparam int WIDE_W = AW + IDX_W;

	state_t state_q, state_d;

	// configuration registers
	logic [15:0]        stagger_q;
	logic [15:0]        fade_q;
	logic [GROUP_W-1:0] group_q;

	// item registers
	logic [TICK_W-1:0]   t_q;
	logic                range_q;
	logic [COLOUR_W-1:0] start_rd_q, end_rd_q;
	logic [ORDER_W-1:0]  order_rd_q;
	logic [BEGIN_W-1:0]  begin_q;
	logic [15:0]         u_q;
	logic [1:0]          chan_q;
	logic                term_q;
	logic [8:0]          acc_q;
	logic [COLOUR_W-1:0] res_q;
	logic                done_q;

	// shared divider registers
	logic [15:0] div_rem_q;
	logic [7:0]  div_word_q;
	logic [7:0]  div_quo_q;
	logic [2:0]  div_cnt_q;

	// output register
	logic                out_valid_q;
	logic [COLOUR_W-1:0] colour_out_q;
	logic                fade_done_q;

	// memories
	logic [COLOUR_W-1:0] start_mem [LED_TOTAL];
	logic [COLOUR_W-1:0] end_mem   [LED_TOTAL];
	logic [ORDER_W-1:0]  order_mem [LED_TOTAL];

	// control outputs of the sequencer
	logic in_take;
	logic out_load;
	logic div_last;

	// address decode
	logic [WIDE_W-1:0] idx_wide;
	logic [AW-1:0]     addr;
	logic              in_range;

	assign idx_wide = {{AW{1'b0}}, led_index};
	assign addr     = idx_wide[AW-1:0];
	assign in_range = idx_wide < WIDE_W'(LED_TOTAL);

	// divider step
	logic [15:0] divisor;
	logic [6:0]  group_eff;
	logic [16:0] div_shift;
	logic        div_ge;
	logic [16:0] div_diff;

	assign group_eff = (group_q == '0) ? GROUP_W'(1) : group_q;
	assign divisor   = (state_q == S_ORD_DIV) ? {9'd0, group_eff} : fade_q;
	assign div_shift = {div_rem_q, div_word_q[7]};
	assign div_ge    = div_shift >= {1'b0, divisor};
	assign div_diff  = div_shift - {1'b0, divisor};

	// begin/finish times and compare
	logic [BEGIN_W-1:0] begin_prod;
	logic [22:0]        finish;
	logic               before_start;
	logic               after_end;
	logic [TICK_W-1:0]  since_start;

	assign begin_prod   = BEGIN_W'(stagger_q) * BEGIN_W'(div_quo_q[ORDER_W-1:0]);
	assign finish       = {1'b0, begin_q} + {7'd0, fade_q};
	assign before_start = t_q < {2'b00, begin_q};
	assign after_end    = t_q >= {1'b0, finish};
	assign since_start  = t_q - {2'b00, begin_q};

	// channel operand select and the shared multiplier
	logic [7:0]  s_chan, e_chan;
	logic [15:0] mul_a;
	logic [7:0]  mul_b;
	logic [23:0] mul_p;
	logic [8:0]  acc_sum;

	always_comb begin
		case (chan_q)
			2'd0:    begin s_chan = start_rd_q[23:16]; e_chan = end_rd_q[23:16]; end
			2'd1:    begin s_chan = start_rd_q[15:8];  e_chan = end_rd_q[15:8];  end
			default: begin s_chan = start_rd_q[7:0];   e_chan = end_rd_q[7:0];   end
		endcase
	end

	assign mul_a   = term_q ? u_q : (fade_q - u_q);
	assign mul_b   = term_q ? e_chan : s_chan;
	assign mul_p   = 24'(mul_a) * 24'(mul_b);
	assign acc_sum = acc_q + {1'b0, div_quo_q};

	// handshake signals
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign colour_out = colour_out_q;
	assign fade_done  = fade_done_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (cmd == CMD_EVAL) ? S_ORD_LD : S_FINISH;
				end
			end
			S_ORD_LD:  state_d = S_ORD_DIV;
			S_ORD_DIV: if (div_cnt_q == 3'd7) state_d = S_BEGIN;
			S_BEGIN:   state_d = S_CMP;
			S_CMP: begin
				if (!range_q || before_start || after_end) state_d = S_FINISH;
				else state_d = S_MUL;
			end
			S_MUL:     state_d = S_DIV;
			S_DIV:     if (div_cnt_q == 3'd7) state_d = S_ACC;
			S_ACC: begin
				if (term_q && chan_q == 2'd2) state_d = S_FINISH;
				else state_d = S_MUL;
			end
			S_FINISH:  if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		div_last = 1'b0;
		unique case (state_q)
			S_IDLE:    in_ready = 1'b1;
			S_ORD_DIV: div_last = div_cnt_q == 3'd7;
			S_DIV:     div_last = div_cnt_q == 3'd7;
			S_FINISH:  out_load = !out_valid_q || out_ready;
			default:   ;
		endcase
	end

	assign in_take = in_valid && in_ready;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			stagger_q   <= '0;
			fade_q      <= '0;
			group_q     <= GROUP_W'(1);
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			// configuration writes; indexes beyond the list are dropped
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_STAGGER: stagger_q <= cfg_data;
					CFG_FADE:    fade_q    <= cfg_data;
					CFG_GROUP:   group_q   <= cfg_data[GROUP_W-1:0];
					default:     ;
				endcase
			end
		end
	end

	// memories: write on in-range write items, registered read on every accepted item
	always_ff @(posedge clk) begin
		if (in_take && in_range) begin
			case (cmd)
				CMD_WR_START: start_mem[addr] <= colour_in;
				CMD_WR_END:   end_mem[addr]   <= colour_in;
				CMD_WR_ORDER: order_mem[addr] <= order_value;
				default:      ;
			endcase
		end
		if (in_take) begin
			start_rd_q <= start_mem[addr];
			end_rd_q   <= end_mem[addr];
			order_rd_q <= order_mem[addr];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			t_q     <= time_tick;
			range_q <= in_range;
			res_q   <= '0;
			done_q  <= 1'b0;
		end
		if (out_load) begin
			colour_out_q <= res_q;
			fade_done_q  <= done_q;
		end
		case (state_q)
			S_ORD_LD: begin
				div_rem_q  <= '0;
				div_word_q <= {2'b00, order_rd_q};
				div_cnt_q  <= '0;
			end
			S_BEGIN: begin
				begin_q <= begin_prod;
			end
			S_CMP: begin
				chan_q <= '0;
				term_q <= 1'b0;
				acc_q  <= '0;
				u_q    <= since_start[15:0];
				if (!range_q) begin
					res_q  <= '0;
					done_q <= 1'b0;
				end else if (before_start) begin
					res_q <= start_rd_q;
				end else if (after_end) begin
					res_q  <= end_rd_q;
					done_q <= 1'b1;
				end
			end
			S_MUL: begin
				// product < fade * 256, so the upper part starts below the divisor
				div_rem_q  <= mul_p[23:8];
				div_word_q <= mul_p[7:0];
				div_cnt_q  <= '0;
			end
			S_ORD_DIV, S_DIV: begin
				div_rem_q  <= div_ge ? div_diff[15:0] : div_shift[15:0];
				div_word_q <= {div_word_q[6:0], 1'b0};
				div_quo_q  <= {div_quo_q[6:0], div_ge};
				if (!div_last) div_cnt_q <= div_cnt_q + 3'd1;
			end
			S_ACC: begin
				if (!term_q) begin
					acc_q  <= acc_sum;
					term_q <= 1'b1;
				end else begin
					case (chan_q)
						2'd0:    res_q[23:16] <= acc_sum[7:0];
						2'd1:    res_q[15:8]  <= acc_sum[7:0];
						default: res_q[7:0]   <= acc_sum[7:0];
					endcase
					acc_q  <= '0;
					term_q <= 1'b0;
					chan_q <= chan_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> tb/tb_staggered_led_crossfade_unit.sv
// Self-checking testbench for staggered_led_crossfade_unit: directed and random
// table writes and evaluations checked against a built-in crossfade predictor.
// Depends on slcf_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_staggered_led_crossfade_unit;
	import slcf_pkg::*;

	localparam int LEDS        = 64;
	localparam int CYCLE_LIMIT = 900000;
	localparam int PHASE_ITEMS = 120;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_PCT    = 34;

	typedef struct packed {
		logic [COLOUR_W-1:0] colour;
		logic                done;
	} lamp_t;

	// Predicts each LED's color per item and checks the unit's results in order
	class fade_scoreboard;
		logic [COLOUR_W-1:0] start_colour [LEDS];
		logic [COLOUR_W-1:0] end_colour [LEDS];
		logic [ORDER_W-1:0]  led_order [LEDS];
		logic [15:0]         stagger_ticks;
		logic [15:0]         fade_ticks;
		logic [GROUP_W-1:0]  group_size;
		lamp_t               expected_q [$];
		int unsigned         mismatches;
		int unsigned         writes_seen;
		int unsigned         before_seen;
		int unsigned         mid_seen;
		int unsigned         done_seen;

		function new();
			stagger_ticks = '0;
			fade_ticks    = '0;
			group_size    = GROUP_W'(1);
			mismatches    = 0;
			writes_seen   = 0;
			before_seen   = 0;
			mid_seen      = 0;
			done_seen     = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_STAGGER: stagger_ticks = data;
				CFG_FADE:    fade_ticks = data;
				CFG_GROUP:   group_size = data[GROUP_W-1:0];
				default: ;
			endcase
		endfunction

		// start tick of an LED's fade; a group size of zero counts as one
		function logic [31:0] fade_begin(logic [IDX_W-1:0] led);
			logic [31:0] grp;
			logic [31:0] groups;
			grp = (group_size == '0) ? 32'd1 : 32'(group_size);
			groups = 32'(led_order[led]) / grp;
			return 32'(stagger_ticks) * groups;
		endfunction

		// weighted average of one 8-bit channel, both terms truncated
		function logic [7:0] blend(logic [7:0] s, logic [7:0] e, logic [31:0] u,
				logic [31:0] d);
			logic [31:0] v;
			v = ((d - u) * 32'(s)) / d + (u * 32'(e)) / d;
			return v[7:0];
		endfunction

		function void note_item(logic [CMD_W-1:0] c, logic [IDX_W-1:0] led,
				logic [COLOUR_W-1:0] colour, logic [ORDER_W-1:0] ord,
				logic [TICK_W-1:0] tick);
			lamp_t       r;
			logic [31:0] t0;
			logic [31:0] t1;
			logic [31:0] u;
			logic [31:0] d;
			logic [23:0] s;
			logic [23:0] e;
			r = '0;
			case (c)
				CMD_WR_START: begin
					start_colour[led] = colour;
					writes_seen++;
				end
				CMD_WR_END: begin
					end_colour[led] = colour;
					writes_seen++;
				end
				CMD_WR_ORDER: begin
					led_order[led] = ord;
					writes_seen++;
				end
				default: begin
					t0 = fade_begin(led);
					t1 = t0 + 32'(fade_ticks);
					s = start_colour[led];
					e = end_colour[led];
					if (32'(tick) < t0) begin
						r.colour = s;
						before_seen++;
					end else if (32'(tick) >= t1) begin
						r.colour = e;
						r.done = 1'b1;
						done_seen++;
					end else begin
						u = 32'(tick) - t0;
						d = 32'(fade_ticks);
						r.colour = {blend(s[23:16], e[23:16], u, d),
							blend(s[15:8], e[15:8], u, d), blend(s[7:0], e[7:0], u, d)};
						mid_seen++;
					end
				end
			endcase
			expected_q.push_back(r);
		endfunction

		function void check_item(logic [COLOUR_W-1:0] colour, logic done);
			lamp_t x;
			if (expected_q.size() == 0) begin
				$error("unexpected result: colour_out %06h fade_done %0b", colour, done);
				mismatches++;
			end else begin
				x = expected_q.pop_front();
				if (colour !== x.colour) begin
					$error("colour_out: expected %06h, actual %06h", x.colour, colour);
					mismatches++;
				end
				if (done !== x.done) begin
					$error("fade_done: expected %0b, actual %0b", x.done, done);
					mismatches++;
				end
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [CMD_W-1:0]      cmd;
	logic [IDX_W-1:0]      led_index;
	logic [COLOUR_W-1:0]   colour_in;
	logic [ORDER_W-1:0]    order_value;
	logic [TICK_W-1:0]     time_tick;
	logic                  out_valid;
	logic                  out_ready;
	logic [COLOUR_W-1:0]   colour_out;
	logic                  fade_done;

	fade_scoreboard sb;
	bit             no_idle;
	bit             hold_req;
	bit             has_start [LEDS];
	bit             has_end [LEDS];
	bit             has_order [LEDS];
	int unsigned    items_sent;
	int unsigned    settings_used;
	int unsigned    cycle_count = 0;
	logic [CMD_W-1:0] write_cmds [3] = '{CMD_WR_START, CMD_WR_END, CMD_WR_ORDER};

	staggered_led_crossfade_unit uut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: random back-pressure plus one long hold on request
	initial begin
		bit hold_taken;
		hold_taken = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_item(colour_out, fade_done);
	end

	function automatic bit led_loaded(logic [IDX_W-1:0] led);
		return has_start[led] && has_end[led] && has_order[led];
	endfunction

	// tick aimed at the edges of the LED's fade window, inside it, or anywhere at random
	function automatic logic [TICK_W-1:0] pick_tick(logic [IDX_W-1:0] led);
		logic [31:0] t0;
		logic [31:0] span;
		logic [31:0] t;
		t0 = sb.fade_begin(led);
		span = 32'(sb.fade_ticks);
		case ($urandom_range(7))
			0, 1: t = $urandom();
			2: t = (t0 == 0) ? 32'd0 : t0 - 1;
			3: t = t0;
			4: t = (t0 + span == 0) ? 32'd0 : t0 + span - 1;
			5: t = t0 + span;
			default: t = t0 + $urandom_range(span);
		endcase
		return t[TICK_W-1:0];
	endfunction

	task automatic send_item(logic [CMD_W-1:0] c, logic [IDX_W-1:0] led,
			logic [COLOUR_W-1:0] colour, logic [ORDER_W-1:0] ord, logic [TICK_W-1:0] tick);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		led_index <= led;
		colour_in <= colour;
		order_value <= ord;
		time_tick <= tick;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(c, led, colour, ord, tick);
		case (c)
			CMD_WR_START: has_start[led] = 1'b1;
			CMD_WR_END:   has_end[led] = 1'b1;
			CMD_WR_ORDER: has_order[led] = 1'b1;
			default: ;
		endcase
		items_sent++;
	endtask

	task automatic send_eval(logic [IDX_W-1:0] led, logic [TICK_W-1:0] tick);
		send_item(CMD_EVAL, led, COLOUR_W'($urandom()), ORDER_W'($urandom()), tick);
	endtask

	task automatic send_write(logic [CMD_W-1:0] c, logic [IDX_W-1:0] led,
			logic [COLOUR_W-1:0] colour, logic [ORDER_W-1:0] ord);
		send_item(c, led, colour, ord, TICK_W'($urandom()));
	endtask

	// wait until every expected result is back and the unit is idle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(int unsigned stagger, int unsigned fade, int unsigned grp);
		drain();
		set_reg(CFG_STAGGER, CFG_DATA_W'(stagger));
		set_reg(CFG_FADE, CFG_DATA_W'(fade));
		set_reg(CFG_GROUP, CFG_DATA_W'(grp));
		settings_used++;
	endtask

	// mostly full LED loads followed by evaluations, some stray single writes
	task automatic run_random(int unsigned count);
		int unsigned      first;
		int unsigned      roll;
		int unsigned      rot;
		logic [IDX_W-1:0] led;
		logic [IDX_W-1:0] cand;
		bit               found;
		first = items_sent;
		while (items_sent - first < count) begin
			roll = $urandom_range(99);
			found = 1'b0;
			led = IDX_W'($urandom());
			if (roll >= 40) begin
				for (int s = 0; s < LEDS; s++) begin
					cand = led + IDX_W'(s);
					if (!found && led_loaded(cand)) begin
						led = cand;
						found = 1'b1;
					end
				end
			end
			if (found) begin
				send_eval(led, pick_tick(led));
			end else if (roll < 10) begin
				send_write(write_cmds[$urandom_range(2)], led, COLOUR_W'($urandom()),
					ORDER_W'($urandom()));
			end else begin
				rot = $urandom_range(2);
				for (int j = 0; j < 3; j++)
					send_write(write_cmds[(rot + j) % 3], led, COLOUR_W'($urandom()),
						ORDER_W'($urandom()));
			end
		end
	endtask

	int unsigned phase_stagger [8] = '{0, 65535, 1, 40, 1000, 0, 65535, 7};
	int unsigned phase_fade [8]    = '{0, 65535, 1, 200, 5000, 65535, 0, 3};
	int unsigned phase_group [8]   = '{1, 64, 127, 3, 8, 1, 0, 2};

	initial begin
		sb = new();
		no_idle = 1'b0;
		hold_req = 1'b0;
		items_sent = 0;
		settings_used = 0;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_STAGGER;
		cfg_data <= '0;
		in_valid <= 1'b0;
		cmd <= CMD_WR_START;
		led_index <= '0;
		colour_in <= '0;
		order_value <= '0;
		time_tick <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: color extremes, first and last LED, window edges
		apply_setting(16, 64, 2);
		send_write(CMD_WR_START, 0, 24'h000000, ORDER_W'($urandom()));
		send_write(CMD_WR_END, 0, 24'hFFFFFF, ORDER_W'($urandom()));
		send_write(CMD_WR_ORDER, 0, COLOUR_W'($urandom()), 0);
		send_write(CMD_WR_START, 63, 24'hFFFFFF, ORDER_W'($urandom()));
		send_write(CMD_WR_END, 63, 24'h000000, ORDER_W'($urandom()));
		send_write(CMD_WR_ORDER, 63, COLOUR_W'($urandom()), 63);
		send_eval(0, 0);
		send_eval(0, 1);
		send_eval(0, 63);
		send_eval(0, 64);
		send_eval(0, 24'hFFFFFF);
		// LED 63 starts at 16 * (63 / 2) = 496 and ends at 560
		send_eval(63, 0);
		send_eval(63, 495);
		send_eval(63, 496);
		send_eval(63, 528);
		send_eval(63, 559);
		send_eval(63, 560);
		send_eval(63, 24'hFFFFFF);
		send_write(CMD_WR_START, 5, 24'h123456, ORDER_W'($urandom()));
		send_write(CMD_WR_END, 5, 24'hABCDEF, ORDER_W'($urandom()));
		send_write(CMD_WR_ORDER, 5, COLOUR_W'($urandom()), 3);
		send_eval(5, 40);

		// zero fade length and zero group size
		apply_setting(300, 0, 0);
		send_eval(63, 18899);
		send_eval(63, 18900);
		send_eval(0, 0);

		// random phases; the last setting is drawn at random
		for (int p = 0; p < 9; p++) begin
			if (p < 8)
				apply_setting(phase_stagger[p], phase_fade[p], phase_group[p]);
			else
				apply_setting($urandom_range(65535), $urandom_range(65535),
					$urandom_range(1, 64));
			no_idle = (p == 4);
			if (p == 2)
				hold_req = 1'b1;
			run_random(PHASE_ITEMS);
		end
		no_idle = 1'b0;
		drain();
		repeat (80) @(posedge clk);

		$display("Ran %0d items over %0d register settings: %0d table writes, %0d evaluations",
			items_sent, settings_used, sb.writes_seen,
			sb.before_seen + sb.mid_seen + sb.done_seen);
		$display("Evaluations: %0d before fade start, %0d mid-fade, %0d finished.",
			sb.before_seen, sb.mid_seen, sb.done_seen);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> staggered_led_crossfade_unit.f
src/slcf_pkg.sv
src/staggered_led_crossfade_unit.sv
tb/tb_staggered_led_crossfade_unit.sv
